### hw/rtl/clts_pkg.sv
`timescale 1ns / 1ps

package clts_pkg;

    localparam int ROW_W      = 8;
    localparam int X_W        = 11;
    localparam int SPAN_ROW_W = 6;
    localparam int SPAN_X_W   = 10;

    localparam logic [ROW_W-1:0] ROW_EMPTY_TOP = 8'd255;
    localparam logic [ROW_W-1:0] ROW_EMPTY_BOT = 8'd0;

    typedef enum logic
    {
        ST_IDLE,
        ST_WORK
    } ctrl_state_t;

    typedef struct packed
    {
        logic load;
        logic close_top;
        logic close_bot;
        logic open_top;
        logic open_bot;
    } dp_cmd_t;

    typedef struct packed
    {
        logic top_more;
        logic bot_more;
        logic open_top_more;
        logic open_bot_more;
        logic out_free;
    } dp_status_t;

endpackage

### hw/rtl/clts_ctrl.sv
`timescale 1ns / 1ps

module clts_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  clts_pkg::dp_status_t status,
    output clts_pkg::dp_cmd_t    cmd
);
    import clts_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        any_more;

    assign any_more = status.top_more || status.bot_more
                   || status.open_top_more || status.open_bot_more;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (!any_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // passes run strictly in order: close top, close bottom, open top, open bottom
    always_comb
    begin
        in_stall      = 1'b1;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_WORK:
            begin
                cmd.close_top = status.top_more && status.out_free;
                cmd.close_bot = !status.top_more && status.bot_more && status.out_free;
                cmd.open_top  = !status.top_more && !status.bot_more
                             && status.open_top_more;
                cmd.open_bot  = !status.top_more && !status.bot_more
                             && !status.open_top_more && status.open_bot_more;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.close_top, cmd.close_bot, cmd.open_top, cmd.open_bot}))
        else $error("more than one datapath command at once");

    a_close_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.close_top || cmd.close_bot) |-> status.out_free)
        else $error("span issued while output slot busy");

    a_load_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE) && !in_stall)
        else $error("column loaded outside idle");

endmodule

### hw/rtl/clts_datapath.sv
`timescale 1ns / 1ps

module clts_datapath #(
    parameter int ROWS        = 64,
    parameter int COLUMN_BITS = 10
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  clts_pkg::dp_cmd_t                    cmd,
    output clts_pkg::dp_status_t                 status,
    input  logic [clts_pkg::X_W-1:0]             column_x,
    input  logic [clts_pkg::ROW_W-1:0]           top_row,
    input  logic [clts_pkg::ROW_W-1:0]           bottom_row,
    input  logic                                 first_of_plane,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [clts_pkg::SPAN_ROW_W-1:0]      span_row,
    output logic [clts_pkg::SPAN_X_W-1:0]        span_x_start,
    output logic [clts_pkg::SPAN_X_W-1:0]        span_x_end,
    output logic                                 last_span
);
    import clts_pkg::*;

    localparam int              ROW_BITS = $clog2(ROWS);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

    logic [COLUMN_BITS-1:0] start_mem [ROWS];

    logic [ROW_W-1:0]       prev_top_reg;
    logic [ROW_W-1:0]       prev_bottom_reg;
    logic [ROW_W-1:0]       t1_reg;
    logic [ROW_W-1:0]       b1_reg;
    logic [ROW_W-1:0]       t2_reg;
    logic [ROW_W-1:0]       b2_reg;
    logic [COLUMN_BITS-1:0] x_reg;
    logic [COLUMN_BITS-1:0] x_end_reg;
    logic [COLUMN_BITS-1:0] rd_data_reg;
    logic                   out_valid_reg;
    logic [SPAN_ROW_W-1:0]  out_row_reg;
    logic [COLUMN_BITS-1:0] out_x_end_reg;
    logic                   out_last_reg;

    logic                   col_empty;
    logic [ROW_W-1:0]       cur_top;
    logic [ROW_W-1:0]       cur_bot;
    logic [ROW_W:0]         t1w;
    logic [ROW_W:0]         b1w;
    logic [ROW_W:0]         t2w;
    logic [ROW_W:0]         b2w;
    logic [ROW_W:0]         nt1;
    logic [ROW_W:0]         nb1;
    logic                   last_top;
    logic                   last_bot;
    logic                   mem_wr;
    logic [ROW_BITS-1:0]    wr_addr;
    logic                   mem_rd;
    logic [ROW_BITS-1:0]    rd_addr;

    // empty test on raw values, saturation only for covered columns
    assign col_empty = top_row > bottom_row;
    assign cur_top   = col_empty ? ROW_EMPTY_TOP : ((top_row > ROW_MAX) ? ROW_MAX : top_row);
    assign cur_bot   = col_empty ? ROW_EMPTY_BOT
                                 : ((bottom_row > ROW_MAX) ? ROW_MAX : bottom_row);

    assign t1w = {1'b0, t1_reg};
    assign b1w = {1'b0, b1_reg};
    assign t2w = {1'b0, t2_reg};
    assign b2w = {1'b0, b2_reg};
    assign nt1 = t1w + 9'd1;
    assign nb1 = b1w - 9'd1;

    assign status.top_more      = (t1w < t2w) && (t1w <= b1w);
    assign status.bot_more      = (b1w > b2w) && (b1w >= t1w);
    assign status.open_top_more = (t2w < t1w) && (t2w <= b2w);
    assign status.open_bot_more = (b2w > b1w) && (b2w >= t2w);
    assign status.out_free      = !out_valid_reg || !out_stall;

    assign last_top = !((nt1 < t2w) && (nt1 <= b1w)) && !((b1w > b2w) && (b1w >= nt1));
    assign last_bot = !((nb1 > b2w) && (nb1 >= t1w));

    assign mem_wr  = cmd.open_top || cmd.open_bot;
    assign wr_addr = cmd.open_top ? t2_reg[ROW_BITS-1:0] : b2_reg[ROW_BITS-1:0];
    assign mem_rd  = cmd.close_top || cmd.close_bot;
    assign rd_addr = cmd.close_top ? t1_reg[ROW_BITS-1:0] : b1_reg[ROW_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_top_reg    <= ROW_EMPTY_TOP;
            prev_bottom_reg <= ROW_EMPTY_BOT;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                prev_top_reg    <= cur_top;
                prev_bottom_reg <= cur_bot;
            end
            if (mem_rd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t1_reg    <= first_of_plane ? ROW_EMPTY_TOP : prev_top_reg;
            b1_reg    <= first_of_plane ? ROW_EMPTY_BOT : prev_bottom_reg;
            t2_reg    <= cur_top;
            b2_reg    <= cur_bot;
            x_reg     <= COLUMN_BITS'(column_x);
            x_end_reg <= COLUMN_BITS'(column_x - 11'd1);
        end
        if (cmd.close_top)
        begin
            t1_reg <= nt1[ROW_W-1:0];
        end
        if (cmd.close_bot)
        begin
            b1_reg <= nb1[ROW_W-1:0];
        end
        if (cmd.open_top)
        begin
            t2_reg <= t2_reg + 8'd1;
        end
        if (cmd.open_bot)
        begin
            b2_reg <= b2_reg - 8'd1;
        end
        if (mem_rd)
        begin
            out_row_reg   <= SPAN_ROW_W'(cmd.close_top ? t1_reg : b1_reg);
            out_x_end_reg <= x_end_reg;
            out_last_reg  <= cmd.close_top ? last_top : last_bot;
        end
    end

    // start column store, read data held until the next span is issued
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            start_mem[wr_addr] <= x_reg;
        end
        if (mem_rd)
        begin
            rd_data_reg <= start_mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign span_row     = out_row_reg;
    assign span_x_start = SPAN_X_W'(rd_data_reg);
    assign span_x_end   = SPAN_X_W'(out_x_end_reg);
    assign last_span    = out_last_reg;

    a_last_ends_closing: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.close_top && last_top) || (cmd.close_bot && last_bot))
        |=> !status.top_more && !status.bot_more)
        else $error("rows still to close after last span of column");

endmodule

### hw/rtl/column_to_span_converter.sv
`timescale 1ns / 1ps

// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------------------------
// column   | in        | in_valid / in_stall | column_x, top_row, bottom_row, first_of_plane
// span     | out       | out_valid/out_stall | span_row, span_x_start, span_x_end, last_span
//
// a column is loaded, then its rows are closed and opened one row per cycle
// through the single-port start column store; a closing row waits while a stalled span
// holds the output register
// a new column is taken only once the previous one has finished all its passes
// the last span of a column may still sit in the output register then
// reset clears control state and the previous extent (empty); start store is not cleared
// out_stall holds the span in its register and pauses the closing passes

module column_to_span_converter #(
    parameter int ROWS        = 64,
    parameter int COLUMN_BITS = 10
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [clts_pkg::X_W-1:0]         column_x,
    input  logic [clts_pkg::ROW_W-1:0]       top_row,
    input  logic [clts_pkg::ROW_W-1:0]       bottom_row,
    input  logic                             first_of_plane,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [clts_pkg::SPAN_ROW_W-1:0]  span_row,
    output logic [clts_pkg::SPAN_X_W-1:0]    span_x_start,
    output logic [clts_pkg::SPAN_X_W-1:0]    span_x_end,
    output logic                             last_span
);
    import clts_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    clts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    clts_datapath #(
        .ROWS        (ROWS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .column_x       (column_x),
        .top_row        (top_row),
        .bottom_row     (bottom_row),
        .first_of_plane (first_of_plane),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .span_row       (span_row),
        .span_x_start   (span_x_start),
        .span_x_end     (span_x_end),
        .last_span      (last_span)
    );

endmodule
